/* hw/rtl/pbsa_pkg.sv */
// ----------------------------------------------------------------------------
// pbsa_pkg
// Shared constants, codes and types for the paged bitmap slot allocator.
// ----------------------------------------------------------------------------
package pbsa_pkg;

  localparam int SLOTS  = 32;
  localparam int PAGES  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int PAGE_W = $clog2(PAGES);
  localparam int CNT_W  = $clog2(PAGES + 1);
  localparam int LIM_W  = 5;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(PAGES);

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_BAD_PAGE  = 2'd2;

  // write controls from the sequencer to the page store
  typedef struct packed {
    logic              map_we;
    logic [PAGE_W-1:0] map_addr;
    logic [SLOTS-1:0]  map_data;
    logic              ord_we;
    logic [PAGE_W-1:0] ord_addr;
    logic [PAGE_W-1:0] ord_data;
  } store_wr_t;

endpackage

/* hw/rtl/pbsa_zero_find.sv */
// ----------------------------------------------------------------------------
// pbsa_zero_find
// Lowest-clear-bit finder, shared by slot search and page-id search.
// ----------------------------------------------------------------------------
module pbsa_zero_find (
  input  logic [pbsa_pkg::SLOTS-1:0]  word,
  output logic                        found,
  output logic [pbsa_pkg::SLOT_W-1:0] index
);

  always_comb begin
    found = 1'b0;
    index = '0;
    for (int i = pbsa_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        found = 1'b1;
        index = pbsa_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

/* hw/rtl/pbsa_page_store.sv */
// ----------------------------------------------------------------------------
// pbsa_page_store
// Per-page used-slot bitmaps and the ordered list of open page ids.
// ----------------------------------------------------------------------------
module pbsa_page_store (
  input  logic                        clk,
  input  logic                        rst,
  input  pbsa_pkg::store_wr_t         wr,
  input  logic [pbsa_pkg::PAGE_W-1:0] map_raddr,
  input  logic [pbsa_pkg::PAGE_W-1:0] ord_raddr,
  output logic [pbsa_pkg::SLOTS-1:0]  map_rdata,
  output logic [pbsa_pkg::PAGE_W-1:0] ord_rdata
);

  logic [pbsa_pkg::SLOTS-1:0]  slot_map   [pbsa_pkg::PAGES];
  logic [pbsa_pkg::PAGE_W-1:0] page_order [pbsa_pkg::PAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pbsa_pkg::PAGES; i++) begin
        slot_map[i] <= '0;
      end
    end else if (wr.map_we) begin
      slot_map[wr.map_addr] <= wr.map_data;
    end
  end

  // only the head of the list is defined after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      page_order[0] <= '0;
    end else if (wr.ord_we) begin
      page_order[wr.ord_addr] <= wr.ord_data;
    end
  end

  assign map_rdata = slot_map[map_raddr];
  assign ord_rdata = page_order[ord_raddr];

endmodule

/* hw/rtl/paged_bitmap_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// paged_bitmap_slot_allocator_unit
// Slot allocator over pages with per-page bitmaps and an ordered page list.
// ----------------------------------------------------------------------------
// Allocate: walks the open pages in list order (one list entry per cycle) until
//   it meets a non-full one; when none has a free slot, an open step follows,
//   in which a page opens or the pool is reported exhausted.
// Release: clears the slot; closing a page adds a search that locates it in
//   the list and a shift that moves the tail down one entry a cycle.
// One transaction in flight; next input taken the cycle after the result is queued.
// Synchronous reset: page 0 open and empty, page_limit = 16, no result pending.
module paged_bitmap_slot_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cmd,
  input  logic [pbsa_pkg::PAGE_W-1:0] release_page,
  input  logic [pbsa_pkg::SLOT_W-1:0] release_slot,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pbsa_pkg::PAGE_W-1:0] result_page,
  output logic [pbsa_pkg::SLOT_W-1:0] result_slot,
  output logic [1:0]                  status,
  output logic                        page_opened,
  output logic                        page_closed,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pbsa_pkg::LIM_W-1:0]  page_limit
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_OPEN  = 8'b0000_0100,
    S_REL   = 8'b0000_1000,
    S_FIND  = 8'b0001_0000,
    S_SHIFT = 8'b0010_0000,
    S_DONE  = 8'b0100_0000
  } state_t;

  state_t                      state;
  logic [pbsa_pkg::LIM_W-1:0]  limit;
  logic [pbsa_pkg::PAGES-1:0]  flags;
  logic [pbsa_pkg::CNT_W-1:0]  count;
  logic [pbsa_pkg::CNT_W-1:0]  idx;
  logic [pbsa_pkg::CNT_W-1:0]  idx_inc;
  logic [pbsa_pkg::PAGE_W-1:0] rpage;
  logic [pbsa_pkg::SLOT_W-1:0] rslot;

  logic [pbsa_pkg::PAGE_W-1:0] res_page;
  logic [pbsa_pkg::SLOT_W-1:0] res_slot;
  logic [1:0]                  res_status;
  logic                        res_open;
  logic                        res_close;

  pbsa_pkg::store_wr_t         wr;
  logic [pbsa_pkg::PAGE_W-1:0] map_raddr;
  logic [pbsa_pkg::PAGE_W-1:0] ord_raddr;
  logic [pbsa_pkg::SLOTS-1:0]  map_rdata;
  logic [pbsa_pkg::PAGE_W-1:0] ord_rdata;

  logic [pbsa_pkg::SLOTS-1:0]  zf_word;
  logic                        zf_found;
  logic [pbsa_pkg::SLOT_W-1:0] zf_index;

  logic [pbsa_pkg::LIM_W-1:0]  eff_limit;
  logic                        in_list;
  logic                        page_full;
  logic                        open_ok;
  logic [pbsa_pkg::SLOTS-1:0]  rel_map;
  logic                        rel_empty;

  pbsa_page_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .map_raddr (map_raddr),
    .ord_raddr (ord_raddr),
    .map_rdata (map_rdata),
    .ord_rdata (ord_rdata)
  );

  pbsa_zero_find u_zero_find (
    .word  (zf_word),
    .found (zf_found),
    .index (zf_index)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  assign idx_inc   = idx + pbsa_pkg::CNT_W'(1);
  assign ord_raddr = (state == S_SHIFT) ? idx_inc[pbsa_pkg::PAGE_W-1:0]
                                        : idx[pbsa_pkg::PAGE_W-1:0];
  assign map_raddr = (state == S_REL) ? rpage : ord_rdata;

  // page-id search pads the unused top with ones so they never match
  assign zf_word = (state == S_OPEN)
                   ? {{(pbsa_pkg::SLOTS - pbsa_pkg::PAGES){1'b1}}, flags}
                   : map_rdata;

  always_comb begin
    if (limit == '0) begin
      eff_limit = pbsa_pkg::LIM_W'(1);
    end else if (limit > pbsa_pkg::LIM_W'(pbsa_pkg::PAGES)) begin
      eff_limit = pbsa_pkg::LIM_W'(pbsa_pkg::PAGES);
    end else begin
      eff_limit = limit;
    end
  end

  assign in_list   = (idx < count);
  assign page_full = &map_rdata;
  assign open_ok   = (pbsa_pkg::LIM_W'(count) < eff_limit) && zf_found;
  assign rel_map   = map_rdata & ~(pbsa_pkg::SLOTS'(1) << rslot);
  assign rel_empty = (rel_map == '0);

  always_comb begin
    wr = '0;
    case (state)
      S_SCAN: begin
        if (in_list && !page_full) begin
          wr.map_we   = 1'b1;
          wr.map_addr = ord_rdata;
          wr.map_data = map_rdata | (pbsa_pkg::SLOTS'(1) << zf_index);
        end
      end
      S_OPEN: begin
        if (open_ok) begin
          wr.map_we   = 1'b1;
          wr.map_addr = zf_index[pbsa_pkg::PAGE_W-1:0];
          wr.map_data = pbsa_pkg::SLOTS'(1);
          wr.ord_we   = 1'b1;
          wr.ord_addr = count[pbsa_pkg::PAGE_W-1:0];
          wr.ord_data = zf_index[pbsa_pkg::PAGE_W-1:0];
        end
      end
      S_REL: begin
        if (flags[rpage]) begin
          wr.map_we   = 1'b1;
          wr.map_addr = rpage;
          wr.map_data = rel_map;
        end
      end
      S_SHIFT: begin
        if (idx_inc < count) begin
          wr.ord_we   = 1'b1;
          wr.ord_addr = idx[pbsa_pkg::PAGE_W-1:0];
          wr.ord_data = ord_rdata;
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      limit     <= pbsa_pkg::LIMIT_RESET;
      flags     <= pbsa_pkg::PAGES'(1);
      count     <= pbsa_pkg::CNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        limit <= page_limit;
      end
      // S_DONE reloads the output register itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            rpage      <= release_page;
            rslot      <= release_slot;
            idx        <= '0;
            res_page   <= '0;
            res_slot   <= '0;
            res_status <= pbsa_pkg::ST_OK;
            res_open   <= 1'b0;
            res_close  <= 1'b0;
            state      <= (cmd == pbsa_pkg::CMD_RELEASE) ? S_REL : S_SCAN;
          end
        end
        S_SCAN: begin
          if (!in_list) begin
            state <= S_OPEN;
          end else if (!page_full) begin
            res_page <= ord_rdata;
            res_slot <= zf_index;
            state    <= S_DONE;
          end else begin
            idx <= idx_inc;
          end
        end
        S_OPEN: begin
          if (open_ok) begin
            flags[zf_index[pbsa_pkg::PAGE_W-1:0]] <= 1'b1;
            count    <= count + pbsa_pkg::CNT_W'(1);
            res_page <= zf_index[pbsa_pkg::PAGE_W-1:0];
            res_open <= 1'b1;
          end else begin
            res_status <= pbsa_pkg::ST_EXHAUSTED;
          end
          state <= S_DONE;
        end
        S_REL: begin
          if (!flags[rpage]) begin
            res_status <= pbsa_pkg::ST_BAD_PAGE;
            state      <= S_DONE;
          end else if (count > pbsa_pkg::CNT_W'(1) && rel_empty) begin
            flags[rpage] <= 1'b0;
            res_close    <= 1'b1;
            idx          <= '0;
            state        <= S_FIND;
          end else begin
            state <= S_DONE;
          end
        end
        S_FIND: begin
          if (!in_list) begin
            state <= S_DONE;
          end else if (ord_rdata == rpage) begin
            state <= S_SHIFT;
          end else begin
            idx <= idx_inc;
          end
        end
        S_SHIFT: begin
          if (idx_inc < count) begin
            idx <= idx_inc;
          end else begin
            count <= count - pbsa_pkg::CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            result_page <= res_page;
            result_slot <= res_slot;
            status      <= res_status;
            page_opened <= res_open;
            page_closed <= res_close;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= pbsa_pkg::CNT_W'(pbsa_pkg::PAGES)))
    else $error("open page count out of range");

  a_count_flags: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(flags) == int'(count)))
    else $error("open page count disagrees with open flags");

  a_shift_closing: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> res_close)
    else $error("list shift without a page close");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted transaction did not start");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || !out_stall)) |=> out_valid)
    else $error("finished result not presented");
`endif

endmodule
